FILE: sv/midi_dec_pkg.sv
`timescale 1ns / 1ps

package midi_dec_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NOTE = 2'd1,
    KIND_MOD  = 2'd2,
    KIND_BEND = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] CFG_BLOCK_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_ALL_CHANNELS    = 3'd1;
  localparam logic [2:0] CFG_LISTEN_CHANNEL  = 3'd2;
  localparam logic [2:0] CFG_VEL_SENS        = 3'd3;
  localparam logic [2:0] CFG_RECORD_VELOCITY = 3'd4;
  localparam logic [2:0] CFG_TRANSPOSE_EN    = 3'd5;
  localparam logic [2:0] CFG_TRANSPOSE_AMT   = 3'd6;

  // status high nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  localparam logic [6:0] CC_MOD_WHEEL = 7'd1;
  localparam logic [7:0] NOTE_OFFSET  = 8'd11;
  localparam logic [7:0] NOTE_LIMIT   = 8'd96;
  localparam logic [7:0] VIB_EFFECT   = 8'hA0;

  // volume = vel*sens*64/(127*100) = vel*sens*16/3175
  // q = (p * ceil(2^30/3175)) >> 26, exact below the clamp point and monotone above it
  localparam int         VOL_PROD_W = 34;
  localparam int         VOL_SHIFT  = 26;
  localparam logic [18:0] VOL_RECIP = 19'd338187;
  localparam logic [7:0] VOL_MAX    = 8'd64;
  localparam logic [7:0] VOL_MIN_ON = 8'd1;
  localparam logic [7:0] VOL_SKIP   = 8'hFF;

  typedef struct packed {
    logic              block_enable;
    logic              all_channels;
    logic [4:0]        listen_channel;
    logic [7:0]        velocity_sensitivity;
    logic              record_velocity;
    logic              transpose_enable;
    logic signed [6:0] transpose_amount;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  note;
    logic        vel_on;
    logic [14:0] vel_prod;
    logic        effect_record;
    logic [3:0]  depth;
    logic [12:0] vibrato;
    logic [7:0]  pitch;
    logic        chan_match;
  } dec_t;

  typedef struct packed {
    kind_t       kind;
    logic        note_ok;
    logic [6:0]  note;
    logic        vel_on;
    logic [7:0]  vol_q;
    logic        effect_record;
    logic [3:0]  depth;
    logic [12:0] vibrato;
    logic [7:0]  pitch;
    logic        chan_match;
  } scl_t;

  typedef struct packed {
    kind_t             event_kind;
    logic              note_record;
    logic [6:0]        note_number;
    logic signed [7:0] note_volume;
    logic              effect_record;
    logic [7:0]        effect_param;
    logic [12:0]       vibrato_depth;
    logic signed [7:0] pitch_value;
    logic              channel_match;
  } result_t;

endpackage

FILE: sv/midi_dec_front.sv
`timescale 1ns / 1ps

module midi_dec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  midi_dec_pkg::cfg_t  cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [7:0]          status_byte,
  input  logic [7:0]          first_data,
  input  logic [7:0]          second_data,
  input  logic [1:0]          message_length,
  output logic                dn_valid,
  input  logic                dn_ready,
  output midi_dec_pkg::dec_t  dn_data
);

  logic               s1_valid_r;
  midi_dec_pkg::dec_t s1_data_r;
  midi_dec_pkg::dec_t s1_data_nxt;

  logic        channel_valid_r, channel_valid_nxt;
  logic [12:0] vibrato_r, vibrato_nxt;
  logic [7:0]  pitch_r, pitch_nxt;

  logic       accept;
  logic       msg_ok;
  logic       ch_hit;
  logic [3:0] hi;
  logic [6:0] d1;
  logic [6:0] d2;
  logic [6:0] vel;
  logic [7:0] t0;
  logic [3:0] depth;

  assign up_ready = !s1_valid_r || dn_ready;
  assign accept   = up_valid && up_ready;
  assign dn_valid = s1_valid_r;
  assign dn_data  = s1_data_r;

  assign hi     = status_byte[7:4];
  assign d1     = first_data[6:0];
  assign d2     = (message_length == 2'd3) ? second_data[6:0] : 7'd0;
  assign msg_ok = cfg.block_enable && message_length[1] && status_byte[7] &&
                  (hi != midi_dec_pkg::ST_SYSTEM);
  assign ch_hit = cfg.all_channels ||
                  ((cfg.listen_channel != 5'd0) &&
                   (({1'b0, status_byte[3:0]} + 5'd1) == cfg.listen_channel));
  assign vel    = (hi == midi_dec_pkg::ST_NOTE_ON) ? d2 : 7'd0;
  assign t0     = {1'b0, d1} - midi_dec_pkg::NOTE_OFFSET;
  assign depth  = d2[6:3];

  always_comb begin
    channel_valid_nxt = channel_valid_r;
    vibrato_nxt       = vibrato_r;
    pitch_nxt         = pitch_r;
    s1_data_nxt       = '0;
    s1_data_nxt.kind  = midi_dec_pkg::KIND_NONE;
    s1_data_nxt.note  = cfg.transpose_enable ?
                        t0 + {cfg.transpose_amount[6], cfg.transpose_amount} : t0;
    s1_data_nxt.vel_on   = (vel != 7'd0);
    s1_data_nxt.vel_prod = {8'd0, vel} * {7'd0, cfg.velocity_sensitivity};
    s1_data_nxt.depth    = depth;
    if (msg_ok) begin
      channel_valid_nxt = ch_hit;
      case (hi)
        midi_dec_pkg::ST_NOTE_OFF, midi_dec_pkg::ST_NOTE_ON: begin
          s1_data_nxt.kind = midi_dec_pkg::KIND_NOTE;
        end
        midi_dec_pkg::ST_CTRL: begin
          if (d1 == midi_dec_pkg::CC_MOD_WHEEL) begin
            s1_data_nxt.kind          = midi_dec_pkg::KIND_MOD;
            s1_data_nxt.effect_record = (depth != 4'd0) && ch_hit;
            vibrato_nxt               = {d2, 6'd0};
          end
        end
        midi_dec_pkg::ST_BEND: begin
          s1_data_nxt.kind = midi_dec_pkg::KIND_BEND;
          // centered 14-bit value >> 6: flip the top bit of the upper eight
          pitch_nxt        = {~d2[6], d2[5:0], d1[6]};
        end
        default: begin
        end
      endcase
    end
    s1_data_nxt.chan_match = channel_valid_nxt;
    s1_data_nxt.vibrato    = vibrato_nxt;
    s1_data_nxt.pitch      = pitch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      channel_valid_r <= 1'b1;
      vibrato_r       <= '0;
      pitch_r         <= '0;
    end else begin
      if (up_ready) begin
        s1_valid_r <= up_valid;
      end
      if (accept) begin
        channel_valid_r <= channel_valid_nxt;
        vibrato_r       <= vibrato_nxt;
        pitch_r         <= pitch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= s1_data_nxt;
    end
  end

endmodule

FILE: sv/midi_dec_scale.sv
`timescale 1ns / 1ps

module midi_dec_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  midi_dec_pkg::dec_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output midi_dec_pkg::scl_t dn_data
);

  logic               s2_valid_r;
  midi_dec_pkg::scl_t s2_data_r;
  midi_dec_pkg::scl_t s2_data_nxt;

  logic [midi_dec_pkg::VOL_PROD_W-1:0] prod;
  logic                                note_ok;

  assign up_ready = !s2_valid_r || dn_ready;
  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_data_r;

  assign prod = {{(midi_dec_pkg::VOL_PROD_W-15){1'b0}}, up_data.vel_prod} *
                {{(midi_dec_pkg::VOL_PROD_W-19){1'b0}}, midi_dec_pkg::VOL_RECIP};

  // transposed note is signed; keep 1..95 only
  assign note_ok = !up_data.note[7] && (up_data.note != 8'd0) &&
                   (up_data.note < midi_dec_pkg::NOTE_LIMIT);

  always_comb begin
    s2_data_nxt               = '0;
    s2_data_nxt.kind          = up_data.kind;
    s2_data_nxt.note_ok       = note_ok;
    s2_data_nxt.note          = up_data.note[6:0];
    s2_data_nxt.vel_on        = up_data.vel_on;
    s2_data_nxt.vol_q         = prod[midi_dec_pkg::VOL_SHIFT +: 8];
    s2_data_nxt.effect_record = up_data.effect_record;
    s2_data_nxt.depth         = up_data.depth;
    s2_data_nxt.vibrato       = up_data.vibrato;
    s2_data_nxt.pitch         = up_data.pitch;
    s2_data_nxt.chan_match    = up_data.chan_match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (up_ready) begin
      s2_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s2_data_r <= s2_data_nxt;
    end
  end

endmodule

FILE: sv/midi_dec_out.sv
`timescale 1ns / 1ps

module midi_dec_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  record_velocity,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  midi_dec_pkg::scl_t    up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output midi_dec_pkg::result_t dn_data
);

  logic                  out_valid_r;
  midi_dec_pkg::result_t out_data_r;
  midi_dec_pkg::result_t out_data_nxt;
  logic [7:0]            vol;

  assign up_ready = !out_valid_r || dn_ready;
  assign dn_valid = out_valid_r;
  assign dn_data  = out_data_r;

  always_comb begin
    vol = (up_data.vol_q > midi_dec_pkg::VOL_MAX) ? midi_dec_pkg::VOL_MAX : up_data.vol_q;
    if (up_data.vel_on && (vol == 8'd0)) begin
      vol = midi_dec_pkg::VOL_MIN_ON;
    end
    if (up_data.vel_on && !record_velocity) begin
      vol = midi_dec_pkg::VOL_SKIP;
    end
  end

  always_comb begin
    out_data_nxt               = '0;
    out_data_nxt.event_kind    = up_data.kind;
    out_data_nxt.vibrato_depth = up_data.vibrato;
    out_data_nxt.pitch_value   = up_data.pitch;
    out_data_nxt.channel_match = up_data.chan_match;
    case (up_data.kind)
      midi_dec_pkg::KIND_NOTE: begin
        out_data_nxt.note_volume = vol;
        if (up_data.note_ok) begin
          out_data_nxt.note_number = up_data.note;
          out_data_nxt.note_record = up_data.chan_match;
        end
      end
      midi_dec_pkg::KIND_MOD: begin
        out_data_nxt.effect_record = up_data.effect_record;
        out_data_nxt.effect_param  = midi_dec_pkg::VIB_EFFECT | {4'd0, up_data.depth};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: sv/midi_input_event_decoder_unit.sv
`timescale 1ns / 1ps
// Pipeline: three registered stages (decode, volume scale, output reg) lie between the
// input transfer and the result on out_tdata.
// Throughput: one message per cycle; the volume reciprocal multiply is the middle stage.
// Each stage holds its data under backpressure; intake stalls only once all three stages
// hold a waiting transfer.
// Reset (rst_n low, synchronous): pipeline valid bits cleared, channel state set to
// matched, vibrato and pitch cleared, configuration registers back to their defaults.

module midi_input_event_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status_byte[7:0], first_data[15:8], second_data[23:16], message_length[25:24]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // note_record[0], note_number[7:1], note_volume[15:8], effect_record[16],
  // effect_param[24:17], vibrato_depth[37:25], pitch_value[45:38], channel_match[46]
  output logic [47:0] out_tdata,
  // event_kind[1:0]
  output logic [1:0]  out_tuser
);

  midi_dec_pkg::cfg_t    cfg_r;
  midi_dec_pkg::dec_t    dec_data;
  midi_dec_pkg::scl_t    scl_data;
  midi_dec_pkg::result_t res;
  logic                  dec_valid, dec_ready;
  logic                  scl_valid, scl_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_enable         <= 1'b0;
      cfg_r.all_channels         <= 1'b1;
      cfg_r.listen_channel       <= 5'd1;
      cfg_r.velocity_sensitivity <= 8'd100;
      cfg_r.record_velocity      <= 1'b1;
      cfg_r.transpose_enable     <= 1'b0;
      cfg_r.transpose_amount     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        midi_dec_pkg::CFG_BLOCK_ENABLE:    cfg_r.block_enable         <= cfg_data[0];
        midi_dec_pkg::CFG_ALL_CHANNELS:    cfg_r.all_channels         <= cfg_data[0];
        midi_dec_pkg::CFG_LISTEN_CHANNEL:  cfg_r.listen_channel       <= cfg_data[4:0];
        midi_dec_pkg::CFG_VEL_SENS:        cfg_r.velocity_sensitivity <= cfg_data;
        midi_dec_pkg::CFG_RECORD_VELOCITY: cfg_r.record_velocity      <= cfg_data[0];
        midi_dec_pkg::CFG_TRANSPOSE_EN:    cfg_r.transpose_enable     <= cfg_data[0];
        midi_dec_pkg::CFG_TRANSPOSE_AMT:   cfg_r.transpose_amount     <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  midi_dec_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .up_valid       (in_tvalid),
    .up_ready       (in_tready),
    .status_byte    (in_tdata[7:0]),
    .first_data     (in_tdata[15:8]),
    .second_data    (in_tdata[23:16]),
    .message_length (in_tdata[25:24]),
    .dn_valid       (dec_valid),
    .dn_ready       (dec_ready),
    .dn_data        (dec_data)
  );

  midi_dec_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (scl_valid),
    .dn_ready (scl_ready),
    .dn_data  (scl_data)
  );

  midi_dec_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .record_velocity (cfg_r.record_velocity),
    .up_valid        (scl_valid),
    .up_ready        (scl_ready),
    .up_data         (scl_data),
    .dn_valid        (out_tvalid),
    .dn_ready        (out_tready),
    .dn_data         (res)
  );

  assign out_tuser = res.event_kind;
  assign out_tdata = {1'b0, res.channel_match, res.pitch_value, res.vibrato_depth,
                      res.effect_param, res.effect_record, res.note_volume,
                      res.note_number, res.note_record};

  a_note_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.note_record |->
      (res.event_kind == midi_dec_pkg::KIND_NOTE) && res.channel_match &&
      (res.note_number != 7'd0))
    else $error("note recorded without a matched in-range note");

  a_fx_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.effect_record |->
      (res.event_kind == midi_dec_pkg::KIND_MOD) && res.channel_match &&
      (res.effect_param[3:0] != 4'd0))
    else $error("vibrato recorded without a matched nonzero depth");

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.event_kind == midi_dec_pkg::KIND_NOTE) |->
      (res.note_volume <= 8'sd64) && (res.note_volume >= -8'sd1))
    else $error("note volume outside -1..64");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    scl_valid && !scl_ready |=> scl_valid && $stable(scl_data))
    else $error("scaled stage changed while stalled");

endmodule
